// ===== hw/rtl/lrp_pkg.sv =====
`default_nettype none
package lrp_pkg;
  localparam int RING_PAIRS_DEF = 191;
  localparam logic [63:0] WORD52 = 64'h000F_FFFF_FFFF_FFFF;
  localparam logic [63:0] CHAIN_MUL = 64'd6364136223846793005;
  localparam int CHAIN_SHIFT = 62;
  localparam int LUNG_SHIFT = 12;

  localparam logic [2:0] REG_PAIR_OFFSET = 3'd0;
  localparam logic [2:0] REG_SHIFT_ONE = 3'd1;
  localparam logic [2:0] REG_SHIFT_TWO = 3'd2;
  localparam logic [2:0] REG_MASK_LOW = 3'd3;
  localparam logic [2:0] REG_MASK_HIGH = 3'd4;
  localparam logic [2:0] REG_SEED_HIGH = 3'd5;

  localparam logic CMD_SEED = 1'b0;
  localparam logic CMD_GEN = 1'b1;

  typedef enum logic [3:0] {
    OP_IDLE  = 4'd0,
    OP_SEED  = 4'd1,
    OP_RDA   = 4'd2,
    OP_RDB   = 4'd3,
    OP_RDC   = 4'd4,
    OP_UPD0  = 4'd5,
    OP_UPD1  = 4'd6,
    OP_MUL   = 4'd7,
    OP_RDD   = 4'd8,
    OP_RDE   = 4'd9
  } op_t;

  typedef struct packed {
    op_t  op;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic seed_done;
    logic mul_done;
  } sts_t;
endpackage
`default_nettype wire

// ===== hw/rtl/lrp_ctrl.sv =====
`default_nettype none
module lrp_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  input  wire logic in_cmd,
  input  wire logic out_busy,
  input  wire lrp_pkg::sts_t sts,
  output lrp_pkg::cmd_t      cmd
);
  import lrp_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_SMUL  = 11'b00000000010,
    S_SWR   = 11'b00000000100,
    S_RDA   = 11'b00000001000,
    S_RDB   = 11'b00000010000,
    S_RDC   = 11'b00000100000,
    S_UPD0  = 11'b00001000000,
    S_UPD1  = 11'b00010000000,
    S_WAIT  = 11'b00100000000,
    S_RDD   = 11'b01000000000,
    S_RDE   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  logic acc;

  assign in_tready = (state_r == S_IDLE);
  assign acc = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd.op = OP_IDLE;
    cmd.load = acc;
    case (state_r)
      S_IDLE: begin
        if (acc) state_nxt = (in_cmd == CMD_SEED) ? S_SMUL : S_WAIT;
      end
      S_SMUL: begin
        cmd.op = OP_MUL;
        if (sts.mul_done) state_nxt = S_SWR;
      end
      S_SWR: begin
        cmd.op = OP_SEED;
        state_nxt = sts.seed_done ? S_IDLE : S_SMUL;
      end
      S_WAIT: begin
        if (!out_busy) state_nxt = S_RDA;
      end
      S_RDA: begin
        cmd.op = OP_RDA;
        state_nxt = S_RDB;
      end
      S_RDB: begin
        cmd.op = OP_RDB;
        state_nxt = S_RDC;
      end
      S_RDC: begin
        cmd.op = OP_RDC;
        state_nxt = S_RDD;
      end
      S_RDD: begin
        cmd.op = OP_RDD;
        state_nxt = S_RDE;
      end
      S_RDE: begin
        cmd.op = OP_RDE;
        state_nxt = S_UPD0;
      end
      S_UPD0: begin
        cmd.op = OP_UPD0;
        state_nxt = S_UPD1;
      end
      S_UPD1: begin
        cmd.op = OP_UPD1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  a_tready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_IDLE) else $error("tready outside idle");
  a_gen_seq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RDA |=> state_r == S_RDB) else $error("read sequence broken");
  a_upd_ret: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPD1 |=> in_tready) else $error("no return to idle");
endmodule
`default_nettype wire

// ===== hw/rtl/lrp_dp.sv =====
`default_nettype none
module lrp_dp #(
  parameter int RING_PAIRS = lrp_pkg::RING_PAIRS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire lrp_pkg::cmd_t cmd,
  output lrp_pkg::sts_t    sts,
  input  wire logic [63:0] in_seed,
  input  wire logic        in_mode,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [63:0] cfg_data,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [103:0]     out_tdata,
  output logic             out_busy
);
  import lrp_pkg::*;

  localparam int WORDS = 2 * RING_PAIRS;
  localparam int AW = $clog2(WORDS + 2);
  localparam int MW = $clog2(WORDS);
  localparam int PW = $clog2(RING_PAIRS + 1);
  localparam int OW = (PW > 8) ? PW : 8;
  localparam int RECIP_SH = 24;
  localparam logic [24:0] RECIP = 25'((1 << RECIP_SH) / RING_PAIRS + 1);

  logic [63:0] mem [WORDS];
  logic [63:0] rd_r;

  logic [7:0]  off_r;
  logic [5:0]  s1_r, s2_r;
  logic [63:0] ml_r, mh_r, sh_r;
  logic [PW-1:0] idx_r, nxt_idx, oth;
  logic [63:0] l0_r, l1_r, a0_r, a1_r, b0_r, b1_r, c0_r;
  logic [63:0] prev_r, seed_r, x_r;
  logic [AW-1:0] k_r;
  logic          mode_r;
  logic [1:0]    mph_r;
  logic [31:0]   ml_c, mh_c;
  logic [63:0]   p_ll_r, p_lh_r, p_hl_r;
  logic [63:0]   chain;
  logic          wr_en;
  logic [AW-1:0] wr_a, rd_a;
  logic [63:0]   wr_d;
  logic          rd_en;
  logic [63:0]   n0, n1;
  logic [OW:0]   osum;
  logic [OW-1:0] omod_r;
  logic [32:0]   oprod;
  logic [7:0]    oquo;
  logic [15:0]   orem;
  logic [103:0]  od_r;

  assign ml_c = CHAIN_MUL[31:0];
  assign mh_c = CHAIN_MUL[63:32];
  assign chain = p_ll_r + {p_lh_r[31:0] + p_hl_r[31:0], 32'd0}
               + {{(64-AW){1'b0}}, k_r};

  // offset modulo ring size by reciprocal multiply
  assign oprod = 33'(off_r) * 33'(RECIP);
  assign oquo = oprod[RECIP_SH+7:RECIP_SH];
  assign orem = 16'(off_r) - 16'(oquo) * 16'(RING_PAIRS);

  assign nxt_idx = (idx_r == PW'(RING_PAIRS - 1)) ? '0 : idx_r + 1'b1;
  assign osum = (OW+1)'(idx_r) + (OW+1)'(omod_r);
  assign oth = (osum >= (OW+1)'(RING_PAIRS)) ? PW'(osum - (OW+1)'(RING_PAIRS)) : PW'(osum);

  assign n0 = ((l0_r ^ a0_r) << s1_r) ^ l1_r ^ ((l0_r ^ (b0_r & ml_r)) << s2_r);
  assign n1 = ((l1_r ^ a1_r) << s1_r) ^ l0_r ^ ((l1_r ^ (b1_r & mh_r)) << s2_r);

  assign sts.mul_done = (mph_r == 2'd2);
  assign sts.seed_done = (k_r == AW'(WORDS + 1));

  always_comb begin
    rd_en = 1'b0;
    rd_a = '0;
    wr_en = 1'b0;
    wr_a = '0;
    wr_d = '0;
    case (cmd.op)
      OP_RDA: begin
        rd_en = 1'b1;
        rd_a = AW'({idx_r, 1'b0});
      end
      OP_RDB: begin
        rd_en = 1'b1;
        rd_a = AW'({idx_r, 1'b1});
      end
      OP_RDC: begin
        rd_en = 1'b1;
        rd_a = AW'({oth, 1'b0});
      end
      OP_RDD: begin
        rd_en = 1'b1;
        rd_a = AW'({oth, 1'b1});
      end
      OP_RDE: begin
        rd_en = 1'b1;
        rd_a = AW'({nxt_idx, 1'b0});
      end
      OP_SEED: begin
        if (k_r < AW'(WORDS)) begin
          wr_en = 1'b1;
          wr_a = k_r;
          wr_d = (chain & WORD52) | sh_r;
        end else if (k_r == AW'(WORDS)) begin
          // word zero comes from the raw seed
          wr_en = 1'b1;
          wr_a = '0;
          wr_d = (seed_r & WORD52) | sh_r;
        end
      end
      OP_UPD0: begin
        wr_en = 1'b1;
        wr_a = AW'({idx_r, 1'b0});
        wr_d = (n0 >> LUNG_SHIFT) ^ a0_r;
      end
      OP_UPD1: begin
        wr_en = 1'b1;
        wr_a = AW'({idx_r, 1'b1});
        wr_d = (n1 >> LUNG_SHIFT) ^ a1_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_a[MW-1:0]] <= wr_d;
    if (rd_en) rd_r <= mem[rd_a[MW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= 8'd1; s1_r <= 6'd13; s2_r <= 6'd13;
      ml_r <= 64'd17149707363846717373; mh_r <= 64'd12609797290232512479; sh_r <= '0;
      idx_r <= '0; out_tvalid <= 1'b0; mph_r <= '0;
      omod_r <= OW'(1);
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_PAIR_OFFSET: off_r <= cfg_data[7:0];
          REG_SHIFT_ONE:   s1_r <= cfg_data[5:0];
          REG_SHIFT_TWO:   s2_r <= cfg_data[5:0];
          REG_MASK_LOW:    ml_r <= cfg_data;
          REG_MASK_HIGH:   mh_r <= cfg_data;
          REG_SEED_HIGH:   sh_r <= cfg_data;
          default: ;
        endcase
      end
      omod_r <= OW'(orem);
      if (cmd.op == OP_UPD1) out_tvalid <= 1'b1;
      else if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      if (cmd.op == OP_MUL) mph_r <= (mph_r == 2'd2) ? 2'd0 : mph_r + 1'b1;
      if (cmd.load) begin
        seed_r <= in_seed;
        prev_r <= in_seed;
        mode_r <= in_mode;
        k_r <= AW'(1);
      end
      case (cmd.op)
        OP_MUL: begin
          if (mph_r == 2'd0) begin
            x_r <= prev_r ^ (prev_r >> CHAIN_SHIFT);
          end else if (mph_r == 2'd1) begin
            p_ll_r <= 64'(x_r[31:0]) * 64'(ml_c);
            p_lh_r <= 64'(x_r[31:0]) * 64'(mh_c);
            p_hl_r <= 64'(x_r[63:32]) * 64'(ml_c);
          end
        end
        OP_SEED: begin
          k_r <= k_r + 1'b1;
          if (k_r < AW'(WORDS)) prev_r <= (chain & WORD52) | sh_r;
          else prev_r <= chain;
          if (k_r == AW'(WORDS)) l0_r <= chain;
          if (k_r == AW'(WORDS + 1)) begin
            l1_r <= chain;
            idx_r <= '0;
          end
        end
        OP_RDB: a0_r <= rd_r;
        OP_RDC: a1_r <= rd_r;
        OP_RDD: b0_r <= rd_r;
        OP_RDE: b1_r <= rd_r;
        OP_UPD0: c0_r <= rd_r;
        OP_UPD1: begin
          l0_r <= n0;
          l1_r <= n1;
          idx_r <= nxt_idx;
          od_r <= mode_r ? {c0_r[51:0], a1_r[51:0]} : {a1_r[51:0], a0_r[51:0]};
        end
        default: ;
      endcase
    end
  end

  assign out_busy = out_tvalid;
  assign out_tdata = od_r;
endmodule
`default_nettype wire

// ===== hw/rtl/lung_recursion_prng_104.sv =====
`default_nettype none
// generate: accept, output register check, five single-port ring reads and two
// write-back steps; the result valid is registered at the second write-back
// a result still held in the output register stalls the next generate at the check
// seed: the chain multiplier makes each ring word in turn, then both lung words
// synchronous active-low reset clears control and the pair index, sets config to defaults
// ring contents are undefined until the first seed beat
module lung_recursion_prng_104 #(
  parameter int RING_PAIRS = lrp_pkg::RING_PAIRS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [71:0]  in_tdata,  // seed_value[63:0], output_mode[64]
  input  wire logic         in_tuser,  // command
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [103:0]      out_tdata, // first_word[51:0], second_word[103:52]
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_idx,
  input  wire logic [63:0]  cfg_data
);
  import lrp_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic busy;

  lrp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_cmd(in_tuser), .out_busy(busy), .sts(sts), .cmd(cmd)
  );

  lrp_dp #(.RING_PAIRS(RING_PAIRS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_seed(in_tdata[63:0]), .in_mode(in_tdata[64]),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_busy(busy)
  );
endmodule
`default_nettype wire

// ===== tb/lung_recursion_prng_104_tb.sv =====
module lung_recursion_prng_104_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lrp_pkg::*;

  localparam int NPAIRS = RING_PAIRS_DEF;
  localparam int SEED_DRAIN = 4 * (2 * NPAIRS + 2) + 400;

  typedef struct {
    logic        cmd;
    logic [63:0] seed;
    logic        mode;
  } beat_t;

  typedef struct {
    logic [51:0] first;
    logic [51:0] second;
  } word_pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [71:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [103:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_idx = '0;
  logic [63:0] cfg_data = '0;

  lung_recursion_prng_104 DUT (.*);

  beat_t pending_beats[$];
  word_pair_t expected_words[$];
  int errors = 0;
  int n_seed = 0, n_gen = 0, n_word = 0, n_cfg = 0;
  bit in_gaps_on = 1'b1;
  bit out_stall_on = 1'b1;
  int in_gap = 0;
  int out_stall = 0;

  // predictor state
  logic [63:0] ring[2*NPAIRS];
  logic [63:0] lung0, lung1;
  int unsigned cur_pair;
  logic [7:0] offset_r;
  logic [5:0] sh1_r, sh2_r;
  logic [63:0] mlow_r, mhigh_r, shigh_r;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] chain_word(logic [63:0] p, int k);
    return CHAIN_MUL * (p ^ (p >> CHAIN_SHIFT)) + 64'(k);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic seed_ring(logic [63:0] s);
    logic [63:0] p;
    p = s;
    for (int k = 1; k < 2 * NPAIRS; k++) begin
      ring[k] = (chain_word(p, k) & WORD52) | shigh_r;
      p = ring[k];
    end
    ring[0] = (s & WORD52) | shigh_r;
    lung0 = chain_word(p, 2 * NPAIRS);
    lung1 = chain_word(lung0, 2 * NPAIRS + 1);
    cur_pair = 0;
  endtask

  task automatic generate_pair(logic mode);
    int unsigned nxt, oth;
    logic [63:0] a0, a1, b0, b1, n0, n1;
    word_pair_t w;
    nxt = (cur_pair + 1 >= NPAIRS) ? 0 : cur_pair + 1;
    if (!mode) begin
      w.first = ring[2*cur_pair][51:0];
      w.second = ring[2*cur_pair+1][51:0];
    end else begin
      w.first = ring[2*cur_pair+1][51:0];
      w.second = ring[2*nxt][51:0];
    end
    expected_words.push_back(w);
    oth = (cur_pair + offset_r) % NPAIRS;
    a0 = ring[2*cur_pair];
    a1 = ring[2*cur_pair+1];
    b0 = ring[2*oth];
    b1 = ring[2*oth+1];
    n0 = ((lung0 ^ a0) << sh1_r) ^ lung1 ^ ((lung0 ^ (b0 & mlow_r)) << sh2_r);
    n1 = ((lung1 ^ a1) << sh1_r) ^ lung0 ^ ((lung1 ^ (b1 & mhigh_r)) << sh2_r);
    lung0 = n0;
    lung1 = n1;
    ring[2*cur_pair] = (n0 >> LUNG_SHIFT) ^ a0;
    ring[2*cur_pair+1] = (n1 >> LUNG_SHIFT) ^ a1;
    cur_pair = nxt;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PAIR_OFFSET: offset_r = val[7:0];
      REG_SHIFT_ONE:   sh1_r = val[5:0];
      REG_SHIFT_TWO:   sh2_r = val[5:0];
      REG_MASK_LOW:    mlow_r = val;
      REG_MASK_HIGH:   mhigh_r = val;
      REG_SEED_HIGH:   shigh_r = val;
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic push_beat(logic cmd, logic [63:0] s, logic mode);
    beat_t b;
    b.cmd = cmd;
    b.seed = s;
    b.mode = mode;
    pending_beats.push_back(b);
  endtask

  task automatic wait_idle();
    wait (pending_beats.size() == 0 && !in_tvalid && expected_words.size() == 0);
    repeat (SEED_DRAIN) @(posedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    beat_t b;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_tready) begin
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
      in_tvalid <= 1'b0;
    end else if (pending_beats.size() > 0) begin
      b = pending_beats.pop_front();
      in_tuser <= b.cmd;
      in_tdata <= {7'b0, b.mode, b.seed};
      in_tvalid <= 1'b1;
      in_gap <= in_gaps_on ? pick_gap() : 0;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // prediction on accepted input beats
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      if (in_tuser == CMD_SEED) begin
        seed_ring(in_tdata[63:0]);
        n_seed++;
      end else begin
        generate_pair(in_tdata[64]);
        n_gen++;
      end
    end
  end

  // output backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      out_stall <= out_stall_on ? pick_gap() : 0;
    end
  end

  // result monitor
  always @(posedge clk) begin
    word_pair_t w;
    if (rst_n && out_tvalid && out_tready) begin
      n_word++;
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %h", out_tdata);
      end else begin
        w = expected_words.pop_front();
        if (out_tdata[51:0] !== w.first || out_tdata[103:52] !== w.second) begin
          errors++;
          if (errors <= 10)
            $display("result %0d: expected first %h second %h, got first %h second %h",
                     n_word, w.first, w.second, out_tdata[51:0], out_tdata[103:52]);
        end
      end
    end
  end

  initial begin
    logic [63:0] p_off[6] = '{0, 1, 190, 191, 255, 0};
    logic [63:0] p_s1[6] = '{0, 63, 13, 50, 0, 0};
    logic [63:0] p_s2[6] = '{63, 0, 13, 1, 0, 0};
    logic [63:0] p_ml[6] = '{0, '1, 64'hEE5F_FD7F_FFBD_FBBD, 0, 0, 0};
    logic [63:0] p_mh[6] = '{'1, 0, 64'hAEFF_FDF5_F7DF_BEDF, 0, 0, 0};
    logic [63:0] p_sh[6] = '{'1, 0, 64'h3FF0_0000_0000_0000, 0, 0, 0};
    for (int i = 0; i < 2 * NPAIRS; i++) ring[i] = '0;
    lung0 = '0;
    lung1 = '0;
    cur_pair = 0;
    offset_r = 8'd1;
    sh1_r = 6'd13;
    sh2_r = 6'd13;
    mlow_r = 64'd17149707363846717373;
    mhigh_r = 64'd12609797290232512479;
    shigh_r = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: seed extremes, both modes, queued back to back
    push_beat(CMD_SEED, 64'd0, 1'b0);
    push_beat(CMD_GEN, rand64(), 1'b0);
    push_beat(CMD_GEN, rand64(), 1'b1);
    push_beat(CMD_SEED, '1, 1'b1);
    for (int i = 0; i < 6; i++) push_beat(CMD_GEN, '1, i[0]);
    push_beat(CMD_SEED, rand64(), 1'b0);
    for (int i = 0; i < 8; i++) push_beat(CMD_GEN, 64'd0, i[1]);
    wait_idle();

    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        write_reg(REG_PAIR_OFFSET, ph < 6 ? p_off[ph-1] : 64'($urandom_range(0, 255)));
        write_reg(REG_SHIFT_ONE, ph < 5 ? p_s1[ph-1] : 64'($urandom_range(0, 63)));
        write_reg(REG_SHIFT_TWO, ph < 5 ? p_s2[ph-1] : 64'($urandom_range(0, 63)));
        write_reg(REG_MASK_LOW, ph < 4 ? p_ml[ph-1] : rand64());
        write_reg(REG_MASK_HIGH, ph < 4 ? p_mh[ph-1] : rand64());
        write_reg(REG_SEED_HIGH, ph < 4 ? p_sh[ph-1] : rand64());
      end
      in_gaps_on = (ph % 3) != 1;
      out_stall_on = (ph % 3) != 2;
      // seed first, then mostly generates, more beats than ring pairs, with random reseeds
      push_beat(CMD_SEED, ph == 1 ? '1 : rand64(), 1'b0);
      for (int i = 0; i < 225; i++) begin
        if ($urandom_range(0, 99) < 3) begin
          case ($urandom_range(0, 3))
            0: push_beat(CMD_SEED, 64'd0, 1'($urandom_range(0, 1)));
            1: push_beat(CMD_SEED, '1, 1'($urandom_range(0, 1)));
            default: push_beat(CMD_SEED, rand64(), 1'($urandom_range(0, 1)));
          endcase
        end else begin
          push_beat(CMD_GEN, rand64(), 1'($urandom_range(0, 1)));
        end
      end
      wait_idle();
    end

    $display("covered %0d seed beats, %0d generate beats, %0d register writes",
             n_seed, n_gen, n_cfg);
    $display("%0d result beats checked, %0d mismatches", n_word, errors);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
